[src/assert_macros.svh]
// Assertion helpers for the mapper RTL. Each macro expects a clock named
// clk and a synchronous active-high reset named rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/bmm_pkg.sv]
// ----------------------------------------------------------------------------
// bmm_pkg
// Types, codes and helper functions of the banked memory mapper.
// ----------------------------------------------------------------------------
package bmm_pkg;

  // Operation codes of one transaction
  localparam logic [1:0] OP_BANK_PORT = 2'd0;
  localparam logic [1:0] OP_PAGE_CTRL = 2'd1;
  localparam logic [1:0] OP_SYS_PORT  = 2'd2;
  localparam logic [1:0] OP_DOS_LATCH = 2'd3;

  // Map geometry
  localparam int MAP_ENTRIES = 8;
  localparam int MAP_IDX_W   = $clog2(MAP_ENTRIES);
  localparam int NUM_BANKS   = 4;
  localparam int BANK_IDX_W  = $clog2(NUM_BANKS);

  // Video mode codes
  localparam logic [2:0] VID_EGA     = 3'd0;
  localparam logic [2:0] VID_HWMC    = 3'd1;
  localparam logic [2:0] VID_STD     = 3'd2;
  localparam logic [2:0] VID_TEXT    = 3'd3;
  localparam logic [2:0] VID_OTHER   = 3'd4;

  // Screen page codes
  localparam logic [2:0] SCREEN_ALT  = 3'd7;
  localparam logic [2:0] SCREEN_MAIN = 3'd5;

  // Page reported while the mapper is disabled
  localparam logic [7:0] DISABLED_PAGE = 8'hff;

  // Bank port bit positions
  localparam int BP_ROM_SEL = 4;
  localparam int BP_LOCK    = 5;
  localparam int BP_SCREEN  = 3;

  typedef struct packed {
    logic       is_ram;
    logic [7:0] page;
  } bank_map_t;

  // Translate system port bits 2:0 to a video mode
  function automatic logic [2:0] video_code(input logic [2:0] sel);
    logic [2:0] code;
    case (sel)
      3'd0:    code = VID_EGA;
      3'd2:    code = VID_HWMC;
      3'd3:    code = VID_STD;
      3'd6:    code = VID_TEXT;
      default: code = VID_OTHER;
    endcase
    return code;
  endfunction

  // Resolve one bank from its map entry
  function automatic bank_map_t bank_calc(input logic [7:0] entry,
                                          input logic [2:0] low_ram,
                                          input logic       dos,
                                          input logic       enable);
    bank_map_t  res;
    logic [5:0] base;
    base = ~entry[5:0];
    if (!enable) begin
      res.is_ram = 1'b0;
      res.page   = DISABLED_PAGE;
    end else begin
      res.is_ram = entry[6];
      if (entry[7] && entry[6]) begin
        res.page = {2'b00, base[5:3], low_ram};
      end else if (entry[7]) begin
        res.page = {2'b00, base[5:1], dos};
      end else begin
        res.page = {2'b00, base};
      end
    end
    return res;
  endfunction

endpackage

[src/banked_memory_mapper_top.sv]
// ----------------------------------------------------------------------------
// banked_memory_mapper_top
// Port-write driven memory mapper: applies one write per transaction and
// reports the mapping of the four banks plus the system mode bits.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | op, port_high, value
//   output  | out_valid / out_ready| bankN_is_ram, bankN_page, video_mode,
//           |                      | turbo_on, keyboard_legacy, screen_page
//
// A transaction runs from acceptance through the shared bank resolver, one bank a
// cycle, and then the result is loaded into the output registers.
// The next transaction is accepted once the sequencer returns to idle; a result
// held by out_ready low stalls the sequencer before the result load.
// Synchronous reset clears the map, latches and result valid; DOS is set.
// ----------------------------------------------------------------------------
module banked_memory_mapper_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] port_high,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       bank0_is_ram,
  output logic [7:0] bank0_page,
  output logic       bank1_is_ram,
  output logic [7:0] bank1_page,
  output logic       bank2_is_ram,
  output logic [7:0] bank2_page,
  output logic       bank3_is_ram,
  output logic [7:0] bank3_page,
  output logic [2:0] video_mode,
  output logic       turbo_on,
  output logic       keyboard_legacy,
  output logic [2:0] screen_page
);

`include "assert_macros.svh"

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [bmm_pkg::BANK_IDX_W-1:0] bidx;

  // Mapper state
  logic [7:0] map_table [bmm_pkg::MAP_ENTRIES];
  logic [7:0] bank_port_latch;
  logic       enable;
  logic       dos_active;
  logic [4:0] mode_bits;

  // Per-bank work results
  bmm_pkg::bank_map_t work [bmm_pkg::NUM_BANKS];
  bmm_pkg::bank_map_t bank_res;

  logic                          accept;
  logic                          load_out;
  logic                          rom_sel;
  logic [bmm_pkg::MAP_IDX_W-1:0] wr_idx;
  logic [bmm_pkg::MAP_IDX_W-1:0] rd_idx;
  logic                          locked;
  logic                          enable_next;
  logic                          dos_upd;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);
  assign rom_sel  = bank_port_latch[bmm_pkg::BP_ROM_SEL];
  assign locked   = bank_port_latch[bmm_pkg::BP_LOCK];
  assign wr_idx   = {rom_sel, port_high[7:6]};
  assign rd_idx   = {rom_sel, bidx};

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_CALC;
      S_CALC: if (bidx == bmm_pkg::BANK_IDX_W'(bmm_pkg::NUM_BANKS - 1)) state_next = S_DONE;
      S_DONE: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bidx  <= '0;
    end else begin
      state <= state_next;
      if (state == S_CALC) begin
        bidx <= bidx + 1'b1;
      end else begin
        bidx <= '0;
      end
    end
  end

  // Apply the port write of an accepted transaction
  always_comb begin
    enable_next = enable;
    dos_upd     = dos_active;
    case (op)
      bmm_pkg::OP_SYS_PORT:  enable_next = port_high[0];
      bmm_pkg::OP_DOS_LATCH: dos_upd     = value[0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bmm_pkg::MAP_ENTRIES; i++) begin
        map_table[i] <= '0;
      end
      bank_port_latch <= '0;
      enable          <= 1'b0;
      dos_active      <= 1'b1;
      mode_bits       <= '0;
    end else if (accept) begin
      case (op)
        bmm_pkg::OP_BANK_PORT: if (!locked) bank_port_latch <= value;
        bmm_pkg::OP_PAGE_CTRL: map_table[wr_idx] <= value;
        bmm_pkg::OP_SYS_PORT:  mode_bits <= {value[6], value[3:0]};
        default: ;
      endcase
      enable     <= enable_next;
      // Force DOS on while the mapper is disabled
      dos_active <= enable_next ? dos_upd : 1'b1;
    end
  end

  // Shared bank resolver: one bank per cycle
  assign bank_res = bmm_pkg::bank_calc(map_table[rd_idx], bank_port_latch[2:0],
                                       dos_active, enable);

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      work[bidx] <= bank_res;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      bank0_is_ram    <= work[0].is_ram;
      bank0_page      <= work[0].page;
      bank1_is_ram    <= work[1].is_ram;
      bank1_page      <= work[1].page;
      bank2_is_ram    <= work[2].is_ram;
      bank2_page      <= work[2].page;
      bank3_is_ram    <= work[3].is_ram;
      bank3_page      <= work[3].page;
      video_mode      <= bmm_pkg::video_code(mode_bits[2:0]);
      turbo_on        <= mode_bits[3];
      keyboard_legacy <= mode_bits[4];
      screen_page     <= bank_port_latch[bmm_pkg::BP_SCREEN] ? bmm_pkg::SCREEN_ALT
                                                             : bmm_pkg::SCREEN_MAIN;
    end
  end

  // Checks
  `ASSERT_NEXT(a_accept_starts_calc, accept, (state == S_CALC) && (bidx == '0))
  `ASSERT_NEXT(a_load_sets_valid, load_out, out_valid && (state == S_IDLE))
  `ASSERT_NOW(a_disabled_forces_dos, !enable, dos_active)
  `ASSERT_NEXT(a_lock_holds_latch, locked, $stable(bank_port_latch))

endmodule

[bench/banked_memory_mapper_top_test.sv]
// ----------------------------------------------------------------------------
// banked_memory_mapper_top_test
// Self-checking bench for the banked memory mapper. A directed sequence
// covers every port write kind, all map flag combinations, both ROM select
// halves, every video code and the disabled mapper. About nine hundred random
// port writes follow and lock the bank port late. A scoreboard keeps its own
// copy of the mapper state and checks every result field by field.
// ----------------------------------------------------------------------------
module banked_memory_mapper_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 925;
  localparam int LOCK_AT      = 850;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // Expected contents of one result transaction
  typedef struct {
    bmm_pkg::bank_map_t bank [bmm_pkg::NUM_BANKS];
    logic [2:0]         video;
    logic               turbo;
    logic               kbd_legacy;
    logic [2:0]         screen;
  } mapping_t;

  // Shadow mapper plus the queue of mappings still to be seen
  class map_scoreboard;
    logic [7:0] page_map [bmm_pkg::MAP_ENTRIES];
    logic       rom_sel;
    logic [7:0] bank_port;
    logic [7:0] enables;
    logic       dos_on;
    logic [4:0] mode;
    mapping_t   pending_maps [$];
    int         fail_count;

    function new();
      foreach (page_map[i]) page_map[i] = 8'h00;
      rom_sel    = 1'b0;
      bank_port  = 8'h00;
      enables    = 8'h00;
      dos_on     = 1'b1;
      mode       = 5'd0;
      fail_count = 0;
    endfunction

    function logic [2:0] video_of(input logic [2:0] sel);
      logic [2:0] code;
      case (sel)
        3'd0:    code = bmm_pkg::VID_EGA;
        3'd2:    code = bmm_pkg::VID_HWMC;
        3'd3:    code = bmm_pkg::VID_STD;
        3'd6:    code = bmm_pkg::VID_TEXT;
        default: code = bmm_pkg::VID_OTHER;
      endcase
      return code;
    endfunction

    // Apply one accepted port write and queue the mapping it produces
    function void note_input(input logic [1:0] op, input logic [7:0] ph,
                             input logic [7:0] val);
      mapping_t   m;
      logic [7:0] entry;
      logic [5:0] base;
      case (op)
        bmm_pkg::OP_BANK_PORT: begin
          if (!bank_port[bmm_pkg::BP_LOCK]) begin
            rom_sel   = val[bmm_pkg::BP_ROM_SEL];
            bank_port = val;
          end
        end
        bmm_pkg::OP_PAGE_CTRL: page_map[rom_sel * 4 + ph[7:6]] = val;
        bmm_pkg::OP_SYS_PORT: begin
          mode    = {val[6], val[3:0]};
          enables = ph;
        end
        default: dos_on = val[0];
      endcase

      // Resolve the four banks, or force ROM everywhere while disabled
      if (enables[0]) begin
        for (int b = 0; b < bmm_pkg::NUM_BANKS; b++) begin
          entry = page_map[rom_sel * 4 + b];
          base  = ~entry[5:0];
          m.bank[b].is_ram = entry[6];
          if (entry[7] && entry[6])
            m.bank[b].page = {2'b00, base[5:3], bank_port[2:0]};
          else if (entry[7])
            m.bank[b].page = {2'b00, base[5:1], dos_on};
          else
            m.bank[b].page = {2'b00, base};
        end
      end else begin
        dos_on = 1'b1;
        for (int b = 0; b < bmm_pkg::NUM_BANKS; b++) begin
          m.bank[b].is_ram = 1'b0;
          m.bank[b].page   = bmm_pkg::DISABLED_PAGE;
        end
      end

      m.video      = video_of(mode[2:0]);
      m.turbo      = mode[3];
      m.kbd_legacy = mode[4];
      m.screen     = bank_port[bmm_pkg::BP_SCREEN] ? bmm_pkg::SCREEN_ALT
                                                   : bmm_pkg::SCREEN_MAIN;
      pending_maps.push_back(m);
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
    endtask

    // Compare one result transaction against the oldest expected mapping
    task check_result(input mapping_t seen);
      mapping_t want;
      if (pending_maps.size() == 0) begin
        report("result arrived with no transaction pending");
        return;
      end
      want = pending_maps.pop_front();
      for (int b = 0; b < bmm_pkg::NUM_BANKS; b++) begin
        if (seen.bank[b].is_ram !== want.bank[b].is_ram)
          report($sformatf("bank%0d_is_ram got %b expected %b", b,
                           seen.bank[b].is_ram, want.bank[b].is_ram));
        if (seen.bank[b].page !== want.bank[b].page)
          report($sformatf("bank%0d_page got %h expected %h", b,
                           seen.bank[b].page, want.bank[b].page));
      end
      if (seen.video !== want.video)
        report($sformatf("video_mode got %0d expected %0d", seen.video, want.video));
      if (seen.turbo !== want.turbo)
        report($sformatf("turbo_on got %b expected %b", seen.turbo, want.turbo));
      if (seen.kbd_legacy !== want.kbd_legacy)
        report($sformatf("keyboard_legacy got %b expected %b",
                         seen.kbd_legacy, want.kbd_legacy));
      if (seen.screen !== want.screen)
        report($sformatf("screen_page got %0d expected %0d", seen.screen, want.screen));
    endtask
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [1:0] op        = bmm_pkg::OP_BANK_PORT;
  logic [7:0] port_high = 8'h00;
  logic [7:0] value     = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       bank0_is_ram, bank1_is_ram, bank2_is_ram, bank3_is_ram;
  logic [7:0] bank0_page, bank1_page, bank2_page, bank3_page;
  logic [2:0] video_mode;
  logic       turbo_on;
  logic       keyboard_legacy;
  logic [2:0] screen_page;

  // Stretches with no idling on either side
  bit             calm = 1'b0;
  int             cycle_count = 0;
  map_scoreboard  sb;

  banked_memory_mapper_top dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one port write after a random gap and hold it until accepted
  task automatic send_item(input logic [1:0] o, input logic [7:0] ph,
                           input logic [7:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    port_high <= ph;
    value     <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_input(o, ph, val);
  endtask

  // Result side: stall before or during a pending result, then take it
  initial begin
    mapping_t seen;
    int       stall;
    bit       late;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      late  = $urandom_range(0, 1);
      if (stall != 0) begin
        out_ready <= 1'b0;
        if (late)
          do @(posedge clk); while (!out_valid);
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen.bank[0].is_ram = bank0_is_ram;
      seen.bank[0].page   = bank0_page;
      seen.bank[1].is_ram = bank1_is_ram;
      seen.bank[1].page   = bank1_page;
      seen.bank[2].is_ram = bank2_is_ram;
      seen.bank[2].page   = bank2_page;
      seen.bank[3].is_ram = bank3_is_ram;
      seen.bank[3].page   = bank3_page;
      seen.video          = video_mode;
      seen.turbo          = turbo_on;
      seen.kbd_legacy     = keyboard_legacy;
      seen.screen         = screen_page;
      sb.check_result(seen);
    end
  end

  // Stimulus
  initial begin
    int         pick;
    logic [1:0] opc;
    logic [7:0] ph;
    logic [7:0] val;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Disabled mapper: DOS latch cleared but forced back on
    send_item(bmm_pkg::OP_DOS_LATCH, 8'h00, 8'h00);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h01, 8'h00);
    // All four flag combinations in the ROM select 0 half
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'h00, 8'h00);
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'h40, 8'h7f);
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'h80, 8'haa);
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'hc0, 8'hc5);
    send_item(bmm_pkg::OP_BANK_PORT, 8'h00, 8'h0f);
    // DOS latch changes, upper value bits ignored
    send_item(bmm_pkg::OP_DOS_LATCH, 8'hff, 8'hfe);
    send_item(bmm_pkg::OP_DOS_LATCH, 8'h00, 8'h01);
    // Switch to the ROM select 1 half and fill it
    send_item(bmm_pkg::OP_BANK_PORT, 8'hff, 8'h17);
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'h3f, 8'hff);
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'h7f, 8'hc0);
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'hbf, 8'h80);
    send_item(bmm_pkg::OP_PAGE_CTRL, 8'hff, 8'h40);
    // Every video code, turbo and legacy keyboard
    send_item(bmm_pkg::OP_SYS_PORT,  8'hff, 8'h4a);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h03, 8'hb3);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h81, 8'h06);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h01, 8'h01);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h01, 8'h0c);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h01, 8'h05);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h01, 8'hff);
    // Disable, try to clear DOS, re-enable
    send_item(bmm_pkg::OP_SYS_PORT,  8'hfe, 8'h00);
    send_item(bmm_pkg::OP_DOS_LATCH, 8'h00, 8'h00);
    send_item(bmm_pkg::OP_SYS_PORT,  8'h01, 8'h00);
    send_item(bmm_pkg::OP_BANK_PORT, 8'hab, 8'h00);

    // Random port writes; the bank port stays unlocked until late in the run
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i % 300) >= 200;
      if (i == LOCK_AT) begin
        send_item(bmm_pkg::OP_BANK_PORT, 8'h00, 8'h39);
        send_item(bmm_pkg::OP_BANK_PORT, 8'hff, 8'hd6);
      end
      pick = $urandom_range(0, 99);
      ph   = $urandom_range(0, 255);
      val  = $urandom_range(0, 255);
      if (pick < 25) begin
        opc = bmm_pkg::OP_BANK_PORT;
        if (i < LOCK_AT)
          val[bmm_pkg::BP_LOCK] = 1'b0;
      end else if (pick < 60) begin
        opc = bmm_pkg::OP_PAGE_CTRL;
      end else if (pick < 80) begin
        opc = bmm_pkg::OP_SYS_PORT;
        if ($urandom_range(0, 9) != 0)
          ph[0] = 1'b1;
      end else begin
        opc = bmm_pkg::OP_DOS_LATCH;
      end
      send_item(opc, ph, val);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (sb.pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/bmm_pkg.sv
src/banked_memory_mapper_top.sv
bench/banked_memory_mapper_top_test.sv
